// ===== design/lrf_pkg.sv =====
// types and constants shared by the rectangle fill sequencer
`timescale 1ns / 1ps
`default_nettype none

package lrf_pkg;

    // panel command bytes
    localparam logic [7:0] CMD_COLUMN   = 8'h2A;
    localparam logic [7:0] CMD_ROW      = 8'h2B;
    localparam logic [7:0] CMD_MEMWRITE = 8'h2C;

    // request kinds
    localparam logic REQ_RECT = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // result status codes
    localparam logic [1:0] ST_TICK     = 2'd0;
    localparam logic [1:0] ST_ACCEPTED = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_BUSY     = 2'd3;

    localparam logic [1:0] ROTATION_RESET = 2'd1;

    // byte sequence position
    typedef enum logic [3:0] {
        PH_COL_CMD,
        PH_XS_HI,
        PH_XS_LO,
        PH_XE_HI,
        PH_XE_LO,
        PH_ROW_CMD,
        PH_YS_HI,
        PH_YS_LO,
        PH_YE_HI,
        PH_YE_LO,
        PH_MEM_CMD,
        PH_PIXELS
    } t_phase;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] bus_byte;
        logic       is_data;
        logic       frame_end;
        logic       rect_done;
        logic [1:0] req_status;
    } t_res;

endpackage

`default_nettype wire

// ===== design/lrf_req_if.sv =====
// request channel: rectangle requests and bus slot ticks
`timescale 1ns / 1ps
`default_nettype none

interface lrf_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
    logic        [15:0] fill_color;

    modport source (
        output valid, req_type, rect_x, rect_y, rect_w, rect_h, fill_color,
        input  ready
    );
    modport sink (
        input  valid, req_type, rect_x, rect_y, rect_w, rect_h, fill_color,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/lrf_res_if.sv =====
// result channel: one bus byte slot per request transfer
`timescale 1ns / 1ps
`default_nettype none

interface lrf_res_if;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] bus_byte;
    logic       is_data;
    logic       frame_end;
    logic       rect_done;
    logic [1:0] req_status;

    modport source (
        output valid, byte_valid, bus_byte, is_data, frame_end, rect_done, req_status,
        input  ready
    );
    modport sink (
        input  valid, byte_valid, bus_byte, is_data, frame_end, rect_done, req_status,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/lcd_rect_fill_bus_sequencer.sv =====
// rectangle fill sequencer for an 8080-style 8-bit lcd bus
//
//  channel   dir  kind         contents
//  i_req     in   valid/ready  req_type, rect_x/y/w/h, fill_color
//  o_res     out  valid/ready  byte_valid, bus_byte, is_data, frame_end,
//                              rect_done, req_status
//  i_cfg_*   in   write only   rotation (2 bits, reset 1)
//
// one request transfer per cycle; its result sits in the output register
// the next cycle. clipping and byte selection are combinational logic.
// i_req.ready is low only while a result waits and o_res.ready is low.
// reset is synchronous: idle, rotation 1, output register empty.
`timescale 1ns / 1ps
`default_nettype none

module lcd_rect_fill_bus_sequencer
    import lrf_pkg::*;
#(
    parameter int PANEL_SHORT = 240,
    parameter int PANEL_LONG  = 320
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [1:0]  i_cfg_wr_data,
    lrf_req_if.sink     i_req,
    lrf_res_if.source   o_res
);

    localparam int PMAX = (PANEL_SHORT > PANEL_LONG) ? PANEL_SHORT : PANEL_LONG;
    localparam int CW   = (PMAX > 1) ? $clog2(PMAX) : 1;

    logic [1:0]    r_rotation;
    logic          r_busy;
    t_phase        r_phase;
    logic [CW-1:0] r_col_start, r_col_end, r_row_start, r_row_end;
    logic [CW-1:0] r_col_span, r_col_left, r_row_left;
    logic [15:0]   r_color;
    logic          r_low_half;
    logic          r_out_valid;
    t_res          r_res;

    logic          n_busy;
    t_phase        n_phase;
    logic [CW-1:0] n_col_start, n_col_end, n_row_start, n_row_end;
    logic [CW-1:0] n_col_span, n_col_left, n_row_left;
    logic [15:0]   n_color;
    logic          n_low_half;
    t_res          n_res;

    logic accept;

    logic signed [17:0] cx, cy, cw, ch, pw, ph, x_end, y_end, w_m1, h_m1;
    logic               nonempty;
    logic        [15:0] coord;
    logic               last_pixel;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;

    // clip the request to the panel
    always_comb begin
        pw = r_rotation[0] ? 18'(PANEL_LONG) : 18'(PANEL_SHORT);
        ph = r_rotation[0] ? 18'(PANEL_SHORT) : 18'(PANEL_LONG);
        cx = 18'(i_req.rect_x);
        cy = 18'(i_req.rect_y);
        cw = 18'(i_req.rect_w);
        ch = 18'(i_req.rect_h);
        if (cw > 0 && ch > 0) begin
            if (cx < 0) begin
                cw = cw + cx;
                cx = '0;
            end
            if (cy < 0) begin
                ch = ch + cy;
                cy = '0;
            end
            if (cx + cw > pw) begin
                cw = pw - cx;
            end
            if (cy + ch > ph) begin
                ch = ph - cy;
            end
        end
        nonempty = (cw > 0) && (ch > 0);
        w_m1     = cw - 18'sd1;
        h_m1     = ch - 18'sd1;
        x_end    = cx + w_m1;
        y_end    = cy + h_m1;
    end

    // coordinate word for the current phase
    always_comb begin
        case (r_phase) inside
            PH_XS_HI, PH_XS_LO: coord = 16'(r_col_start);
            PH_XE_HI, PH_XE_LO: coord = 16'(r_col_end);
            PH_YS_HI, PH_YS_LO: coord = 16'(r_row_start);
            default:            coord = 16'(r_row_end);
        endcase
    end

    assign last_pixel = (r_col_left == '0) && (r_row_left == '0);

    always_comb begin
        n_busy      = r_busy;
        n_phase     = r_phase;
        n_col_start = r_col_start;
        n_col_end   = r_col_end;
        n_row_start = r_row_start;
        n_row_end   = r_row_end;
        n_col_span  = r_col_span;
        n_col_left  = r_col_left;
        n_row_left  = r_row_left;
        n_color     = r_color;
        n_low_half  = r_low_half;
        n_res       = '0;

        if (i_req.req_type == REQ_RECT) begin
            if (r_busy) begin
                n_res.req_status = ST_BUSY;
            end else if (!nonempty) begin
                n_res.req_status = ST_EMPTY;
            end else begin
                n_res.req_status = ST_ACCEPTED;
                n_col_start      = cx[CW-1:0];
                n_col_end        = x_end[CW-1:0];
                n_row_start      = cy[CW-1:0];
                n_row_end        = y_end[CW-1:0];
                n_col_span       = w_m1[CW-1:0];
                n_col_left       = w_m1[CW-1:0];
                n_row_left       = h_m1[CW-1:0];
                n_color          = i_req.fill_color;
                n_low_half       = 1'b0;
                n_phase          = PH_COL_CMD;
                n_busy           = 1'b1;
            end
        end else if (r_busy) begin
            n_res.byte_valid = 1'b1;
            n_res.req_status = ST_TICK;
            if (r_phase != PH_PIXELS) begin
                n_phase = t_phase'(r_phase + 4'd1);
            end
            unique case (r_phase) inside
                PH_COL_CMD: begin
                    n_res.bus_byte  = CMD_COLUMN;
                    n_res.frame_end = 1'b1;
                end
                PH_ROW_CMD: begin
                    n_res.bus_byte  = CMD_ROW;
                    n_res.frame_end = 1'b1;
                end
                PH_MEM_CMD: begin
                    n_res.bus_byte  = CMD_MEMWRITE;
                    n_res.frame_end = 1'b1;
                end
                PH_XS_HI, PH_XE_HI, PH_YS_HI, PH_YE_HI: begin
                    n_res.bus_byte = coord[15:8];
                    n_res.is_data  = 1'b1;
                end
                PH_XS_LO, PH_XE_LO, PH_YS_LO, PH_YE_LO: begin
                    n_res.bus_byte  = coord[7:0];
                    n_res.is_data   = 1'b1;
                    n_res.frame_end = 1'b1;
                end
                default: begin
                    n_res.is_data = 1'b1;
                    if (!r_low_half) begin
                        n_res.bus_byte = r_color[15:8];
                        n_low_half     = 1'b1;
                    end else begin
                        n_res.bus_byte  = r_color[7:0];
                        n_res.frame_end = last_pixel;
                        n_res.rect_done = last_pixel;
                        n_low_half      = 1'b0;
                        if (last_pixel) begin
                            n_busy  = 1'b0;
                            n_phase = PH_COL_CMD;
                        end else if (r_col_left == '0) begin
                            // wrap to the next row
                            n_col_left = r_col_span;
                            n_row_left = r_row_left - 1'b1;
                        end else begin
                            n_col_left = r_col_left - 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation <= ROTATION_RESET;
        end else if (i_cfg_wr_en) begin
            r_rotation <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_COL_CMD;
            r_low_half  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy      <= n_busy;
                r_phase     <= n_phase;
                r_low_half  <= n_low_half;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col_start <= n_col_start;
            r_col_end   <= n_col_end;
            r_row_start <= n_row_start;
            r_row_end   <= n_row_end;
            r_col_span  <= n_col_span;
            r_col_left  <= n_col_left;
            r_row_left  <= n_row_left;
            r_color     <= n_color;
            r_res       <= n_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.byte_valid = r_res.byte_valid;
    assign o_res.bus_byte   = r_res.bus_byte;
    assign o_res.is_data    = r_res.is_data;
    assign o_res.frame_end  = r_res.frame_end;
    assign o_res.rect_done  = r_res.rect_done;
    assign o_res.req_status = r_res.req_status;

endmodule

`default_nettype wire

// ===== sim/lcd_rect_fill_bus_sequencer_tb.sv =====
// testbench for the rectangle fill sequencer: directed table, random requests and ticks
`timescale 1ns / 1ps

module lcd_rect_fill_bus_sequencer_tb;
    import lrf_pkg::*;

    localparam int PANEL_SHORT = 240;
    localparam int PANEL_LONG  = 320;
    localparam int SETUP_BYTES = 11;
    localparam int PHASE_ITEMS = 370;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic        req_type;
        logic [15:0] rect_x;
        logic [15:0] rect_y;
        logic [15:0] rect_w;
        logic [15:0] rect_h;
        logic [15:0] fill_color;
    } t_item;

    typedef struct {
        t_item it;
        bit    typed;
        t_res  want;
    } t_row;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = 2'd0;

    lrf_req_if req_ch ();
    lrf_res_if res_ch ();

    lcd_rect_fill_bus_sequencer #(
        .PANEL_SHORT (PANEL_SHORT),
        .PANEL_LONG  (PANEL_LONG)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_ch),
        .o_res         (res_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    logic [1:0]  fill_rot = ROTATION_RESET;
    bit          fill_busy = 1'b0;
    t_phase      fill_phase = PH_COL_CMD;
    logic [15:0] fill_x0 = '0, fill_x1 = '0, fill_y0 = '0, fill_y1 = '0;
    int unsigned fill_pixels = 0;
    logic [15:0] fill_rgb = '0;
    bit          fill_low_next = 1'b0;

    t_res expected_slots[$];
    int   mismatches = 0;

    // stimulus side bookkeeping: bytes still owed by the running fill
    logic [1:0] gen_rot = ROTATION_RESET;
    int         gen_owed = 0;
    bit         no_gaps = 1'b0;
    bit         pressure_go = 1'b0;

    // typed expectation travels with the payload of the item on the bus
    bit   slot_typed = 1'b0;
    t_res slot_want = '0;

    function automatic bit clip_to_panel(input t_item it, input logic [1:0] rot,
                                         output int x0, output int x1,
                                         output int y0, output int y1);
        int x, y, w, h, pw, ph;
        x = $signed(it.rect_x);
        y = $signed(it.rect_y);
        w = $signed(it.rect_w);
        h = $signed(it.rect_h);
        pw = rot[0] ? PANEL_LONG : PANEL_SHORT;
        ph = rot[0] ? PANEL_SHORT : PANEL_LONG;
        if (w > 0 && h > 0) begin
            if (x < 0) begin
                w += x;
                x = 0;
            end
            if (y < 0) begin
                h += y;
                y = 0;
            end
            if (x + w > pw) w = pw - x;
            if (y + h > ph) h = ph - y;
        end
        x0 = x;
        x1 = x + w - 1;
        y0 = y;
        y1 = y + h - 1;
        return (w > 0 && h > 0);
    endfunction

    task automatic predict_slot(input t_item it, output t_res r);
        int x0, x1, y0, y1;
        t_phase ph;
        r = '0;
        ph = fill_phase;
        if (it.req_type == REQ_RECT) begin
            if (fill_busy) begin
                r.req_status = ST_BUSY;
            end else if (!clip_to_panel(it, fill_rot, x0, x1, y0, y1)) begin
                r.req_status = ST_EMPTY;
            end else begin
                fill_x0 = 16'(x0);
                fill_x1 = 16'(x1);
                fill_y0 = 16'(y0);
                fill_y1 = 16'(y1);
                fill_pixels = (x1 - x0 + 1) * (y1 - y0 + 1);
                fill_rgb = it.fill_color;
                fill_low_next = 1'b0;
                fill_phase = PH_COL_CMD;
                fill_busy = 1'b1;
                r.req_status = ST_ACCEPTED;
            end
        end else if (fill_busy) begin
            r.byte_valid = 1'b1;
            r.is_data = 1'b1;
            case (ph)
                PH_COL_CMD: begin
                    r.bus_byte = CMD_COLUMN;
                    r.is_data = 1'b0;
                    r.frame_end = 1'b1;
                end
                PH_XS_HI: r.bus_byte = fill_x0[15:8];
                PH_XS_LO: begin
                    r.bus_byte = fill_x0[7:0];
                    r.frame_end = 1'b1;
                end
                PH_XE_HI: r.bus_byte = fill_x1[15:8];
                PH_XE_LO: begin
                    r.bus_byte = fill_x1[7:0];
                    r.frame_end = 1'b1;
                end
                PH_ROW_CMD: begin
                    r.bus_byte = CMD_ROW;
                    r.is_data = 1'b0;
                    r.frame_end = 1'b1;
                end
                PH_YS_HI: r.bus_byte = fill_y0[15:8];
                PH_YS_LO: begin
                    r.bus_byte = fill_y0[7:0];
                    r.frame_end = 1'b1;
                end
                PH_YE_HI: r.bus_byte = fill_y1[15:8];
                PH_YE_LO: begin
                    r.bus_byte = fill_y1[7:0];
                    r.frame_end = 1'b1;
                end
                PH_MEM_CMD: begin
                    r.bus_byte = CMD_MEMWRITE;
                    r.is_data = 1'b0;
                    r.frame_end = 1'b1;
                end
                default: begin
                    if (!fill_low_next) begin
                        r.bus_byte = fill_rgb[15:8];
                        fill_low_next = 1'b1;
                    end else begin
                        r.bus_byte = fill_rgb[7:0];
                        r.frame_end = (fill_pixels <= 1);
                        r.rect_done = (fill_pixels <= 1);
                        fill_low_next = 1'b0;
                        if (fill_pixels <= 1) begin
                            fill_busy = 1'b0;
                            fill_phase = PH_COL_CMD;
                        end
                        if (fill_pixels > 0) fill_pixels--;
                    end
                end
            endcase
            if (ph != PH_PIXELS) fill_phase = t_phase'(ph + 1);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        $display("%0t mismatch in %s: got %0h, want %0h", $time, what, got, want);
    endtask

    always @(posedge clk) begin : slot_monitor
        t_res got, want, guess;
        t_item seen;
        if (rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got = '{byte_valid: res_ch.byte_valid, bus_byte: res_ch.bus_byte,
                        is_data: res_ch.is_data, frame_end: res_ch.frame_end,
                        rect_done: res_ch.rect_done, req_status: res_ch.req_status};
                if (expected_slots.size() == 0) begin
                    report_mismatch("unexpected transfer", got.bus_byte, 8'h00);
                end else begin
                    want = expected_slots.pop_front();
                    if (got.byte_valid !== want.byte_valid)
                        report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
                    if (got.bus_byte !== want.bus_byte)
                        report_mismatch("bus_byte", got.bus_byte, want.bus_byte);
                    if (got.is_data !== want.is_data)
                        report_mismatch("is_data", got.is_data, want.is_data);
                    if (got.frame_end !== want.frame_end)
                        report_mismatch("frame_end", got.frame_end, want.frame_end);
                    if (got.rect_done !== want.rect_done)
                        report_mismatch("rect_done", got.rect_done, want.rect_done);
                    if (got.req_status !== want.req_status)
                        report_mismatch("req_status", got.req_status, want.req_status);
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                seen = '{req_type: req_ch.req_type, rect_x: req_ch.rect_x,
                         rect_y: req_ch.rect_y, rect_w: req_ch.rect_w,
                         rect_h: req_ch.rect_h, fill_color: req_ch.fill_color};
                predict_slot(seen, guess);
                expected_slots.push_back(slot_typed ? slot_want : guess);
            end
            if (cfg_wr_en) fill_rot = cfg_wr_data;
        end
    end

    // receiver: random stalls, plus one long hold-off so the block backs up
    initial begin : receiver
        bit pressure_done;
        pressure_done = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (pressure_go && !pressure_done) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                pressure_done = 1'b1;
            end else begin
                res_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 17);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("[lcd_rect_fill_bus_sequencer] ERROR");
        $finish;
    end

    function automatic t_item tick_item();
        t_item it;
        it.req_type   = REQ_TICK;
        it.rect_x     = 16'($urandom);
        it.rect_y     = 16'($urandom);
        it.rect_w     = 16'($urandom);
        it.rect_h     = 16'($urandom);
        it.fill_color = 16'($urandom);
        return it;
    endfunction

    function automatic t_item rect_item(input int x, input int y, input int w,
                                        input int h, input int color);
        t_item it;
        it.req_type   = REQ_RECT;
        it.rect_x     = x[15:0];
        it.rect_y     = y[15:0];
        it.rect_w     = w[15:0];
        it.rect_h     = h[15:0];
        it.fill_color = color[15:0];
        return it;
    endfunction

    function automatic t_row typed(input t_item it, input logic [1:0] status);
        t_row rw;
        rw.it = it;
        rw.typed = 1'b1;
        rw.want = '0;
        rw.want.req_status = status;
        return rw;
    endfunction

    function automatic t_row row_of(input t_item it);
        t_row rw;
        rw.it = it;
        rw.typed = 1'b0;
        rw.want = '0;
        return rw;
    endfunction

    task automatic send_item(input t_row rw);
        int x0, x1, y0, y1;
        if (rw.it.req_type == REQ_TICK) begin
            if (gen_owed > 0) gen_owed--;
        end else if (gen_owed == 0 && clip_to_panel(rw.it, gen_rot, x0, x1, y0, y1)) begin
            gen_owed = SETUP_BYTES + 2 * (x1 - x0 + 1) * (y1 - y0 + 1);
        end
        while (!no_gaps && $urandom_range(0, 99) < 17) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= rw.it.req_type;
        req_ch.rect_x     <= rw.it.rect_x;
        req_ch.rect_y     <= rw.it.rect_y;
        req_ch.rect_w     <= rw.it.rect_w;
        req_ch.rect_h     <= rw.it.rect_h;
        req_ch.fill_color <= rw.it.fill_color;
        slot_typed        <= rw.typed;
        slot_want         <= rw.want;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    task automatic write_rotation(input logic [1:0] rot);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_slots.size() != 0) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rot;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        gen_rot = rot;
    endtask

    task automatic finish_fill();
        while (gen_owed > 0) send_item(row_of(tick_item()));
    endtask

    task automatic run_random(input int n);
        t_item it;
        int k, roll, pw, ph, x0, x1, y0, y1;
        for (k = 0; k < n; k++) begin
            it = tick_item();
            roll = $urandom_range(0, 99);
            pw = gen_rot[0] ? PANEL_LONG : PANEL_SHORT;
            ph = gen_rot[0] ? PANEL_SHORT : PANEL_LONG;
            if (gen_owed > 0) begin
                // a stray request in the middle of a fill gets turned away
                if (roll < 4) it.req_type = REQ_RECT;
            end else if (roll < 60) begin
                it.req_type = REQ_RECT;
                it.rect_w = 16'($urandom_range(1, (roll < 10) ? 24 : 5));
                it.rect_h = 16'($urandom_range(1, 5));
                it.rect_x = 16'($urandom_range(0, pw + 12) - 8);
                it.rect_y = 16'($urandom_range(0, ph + 12) - 8);
            end else if (roll < 80) begin
                // raw fields; keep whatever survives clipping small
                it.req_type = REQ_RECT;
                while (clip_to_panel(it, gen_rot, x0, x1, y0, y1) &&
                       (x1 - x0 + 1) * (y1 - y0 + 1) > 1024) begin
                    it.rect_w = 16'($urandom);
                    it.rect_h = 16'($urandom);
                end
            end
            send_item(row_of(it));
        end
    endtask

    initial begin : stimulus
        t_row directed[$];
        int k;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_TICK;
        req_ch.rect_x     = '0;
        req_ch.rect_y     = '0;
        req_ch.rect_w     = '0;
        req_ch.rect_h     = '0;
        req_ch.fill_color = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // panel is 320 wide and 240 high out of reset
        directed.push_back(typed(tick_item(), ST_TICK));
        directed.push_back(typed(rect_item(0, 0, 0, 5, 16'h1234), ST_EMPTY));
        directed.push_back(typed(rect_item(0, 0, 5, -32768, 16'h0000), ST_EMPTY));
        directed.push_back(typed(rect_item(32767, 32767, 32767, 32767, 16'h0000), ST_EMPTY));
        directed.push_back(typed(rect_item(-32768, -32768, 32767, 32767, 16'hFFFF),
                                 ST_EMPTY));
        directed.push_back(typed(rect_item(320, 0, 1, 1, 16'h5A5A), ST_EMPTY));
        directed.push_back(typed(rect_item(319, 239, 1, 1, 16'hFFFF), ST_ACCEPTED));
        directed.push_back(typed(rect_item(0, 0, 10, 10, 16'h0F0F), ST_BUSY));
        for (k = 0; k < 13; k++) directed.push_back(row_of(tick_item()));
        directed.push_back(typed(tick_item(), ST_TICK));
        directed.push_back(row_of(rect_item(-5, -3, 8, 5, 16'hA5C3)));
        for (k = 0; k < directed.size(); k++) send_item(directed[k]);

        write_rotation(2'd0);
        pressure_go = 1'b1;
        run_random(PHASE_ITEMS);
        write_rotation(2'd3);
        no_gaps = 1'b1;
        run_random(PHASE_ITEMS);
        no_gaps = 1'b0;
        write_rotation(2'd2);
        run_random(PHASE_ITEMS);
        write_rotation(2'd1);
        run_random(PHASE_ITEMS);
        write_rotation(2'd3);
        run_random(PHASE_ITEMS);
        finish_fill();
        // one fill with huge sizes clipped at the far corner of the panel
        send_item(row_of(rect_item(316, 237, 32767, 32767, 16'h8001)));
        finish_fill();

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_slots.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("[lcd_rect_fill_bus_sequencer] OK");
        else
            $display("[lcd_rect_fill_bus_sequencer] ERROR");
        $finish;
    end

endmodule
